FILE: hdl/stereo_linear_resampler_core_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef STEREO_LINEAR_RESAMPLER_CORE_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SLR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/slr_pkg.sv
// Types, constants and helpers shared by the stereo resampler modules.
package slr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAMES_W  = 12;
    localparam int PHASE_W   = FRAMES_W + 1;
    localparam int MAX_RUN   = 4;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    localparam int PROD_W = SAMPLE_W + FRAMES_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int MAG_W  = SAMPLE_W - 1 + FRAMES_W;
    localparam int QUOT_W = SAMPLE_W;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_FRAMES = 2'd1;

    localparam logic [FRAMES_W-1:0] OLD_FRAMES_RESET = 12'd220;
    localparam logic [FRAMES_W-1:0] NEW_FRAMES_RESET = 12'd240;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
    } slr_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first_out;
        logic [SAMPLE_W-1:0] second_out;
        logic                run_end;
    } slr_out_t;

    // Request to the shared interpolation unit.
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic [FRAMES_W-1:0]        ph;
        logic [FRAMES_W-1:0]        div;
    } lerp_req_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] result;
    } lerp_rsp_t;

    function automatic logic [SAMPLE_W-1:0] swap_bytes(input logic [SAMPLE_W-1:0] s);
        return {s[7:0], s[SAMPLE_W-1:8]};
    endfunction

endpackage

FILE: hdl/stereo_linear_resampler_core.sv
// Stereo linear-interpolation rate converter: sequencer, state and channel ports.
// Each accepted frame gives n results (0 to 4); each result takes both channels in
// turn through the shared multiply/divide unit, and an output stall holds the sequencer.
// A new frame is taken only once the run for the last one is over.
// Reset (aresetn low, synchronous): old_frames 220, new_frames 240, previous
// frame and phase zero, output channel empty.

`include "stereo_linear_resampler_core_macros.svh"

module stereo_linear_resampler_core
    import slr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  slr_in_t              s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output slr_out_t             m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAMES_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC_A,
        ST_CALC_B,
        ST_EMIT
    } seq_state_t;

    seq_state_t state_reg;

    // Configuration and carried state.
    logic [FRAMES_W-1:0]  old_frames_reg;
    logic [FRAMES_W-1:0]  new_frames_reg;
    logic [SAMPLE_W-1:0]  prev_first_reg;
    logic [SAMPLE_W-1:0]  prev_second_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [RUN_CNT_W-1:0] run_cnt_reg;

    // Current frame and per-output results.
    logic [SAMPLE_W-1:0]  cur_first_reg;
    logic [SAMPLE_W-1:0]  cur_second_reg;
    logic [SAMPLE_W-1:0]  first_res_reg;
    logic [SAMPLE_W-1:0]  second_res_reg;

    logic     m_valid_reg;
    slr_out_t m_data_reg;

    lerp_req_t req;
    lerp_rsp_t rsp;

    logic [PHASE_W-1:0]    phase_sum;
    logic                  run_go;
    logic                  run_last;
    logic                  emit_go;
    logic [FRAMES_W+1:0]   ratio_lim;
    logic [FRAMES_W-1:0]   new_lim;
    logic [FRAMES_W-1:0]   new_frames_next;

    // Loop test: emit another output while the phase lies below the divisor
    // and the run cap is not reached.
    always_comb begin
        phase_sum = phase_reg + {1'b0, old_frames_reg};
        run_go    = (phase_reg < {1'b0, new_frames_reg})
                    && (run_cnt_reg < RUN_CNT_W'(MAX_RUN));
        // The output about to go out is the last of the run when the loop
        // test fails on the advanced phase or the cap is hit.
        run_last  = (phase_sum >= {1'b0, new_frames_reg})
                    || (run_cnt_reg == RUN_CNT_W'(MAX_RUN - 1));
        // Load the output register once it is empty or being drained.
        emit_go   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    end

    // Clamp new_frames to four times old_frames, itself limited to full scale.
    always_comb begin
        ratio_lim = {old_frames_reg, 2'b00};
        new_lim   = (ratio_lim > {2'b00, {FRAMES_W{1'b1}}}) ? {FRAMES_W{1'b1}}
                                                             : ratio_lim[FRAMES_W-1:0];
        new_frames_next = (cfg_data > new_lim) ? new_lim : cfg_data;
    end

    // Launch the first channel from the loop test, the second as soon as the
    // first comes back. The unit latches operands on start only.
    always_comb begin
        req.start = ((state_reg == ST_CHECK) && run_go)
                    || ((state_reg == ST_CALC_A) && rsp.done);
        req.a     = (state_reg == ST_CALC_A) ? prev_second_reg : prev_first_reg;
        req.b     = (state_reg == ST_CALC_A) ? cur_second_reg : cur_first_reg;
        req.ph    = phase_reg[FRAMES_W-1:0];
        req.div   = new_frames_reg;
    end

    slr_lerp_unit u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            old_frames_reg  <= OLD_FRAMES_RESET;
            new_frames_reg  <= NEW_FRAMES_RESET;
            prev_first_reg  <= '0;
            prev_second_reg <= '0;
            phase_reg       <= '0;
            run_cnt_reg     <= '0;
        end else begin
            // Register writes are to arrive only while the sequencer is idle; the block does not enforce this.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_OLD_FRAMES: old_frames_reg <= cfg_data;
                    REG_NEW_FRAMES: new_frames_reg <= new_frames_next;
                    default: ;
                endcase
            end

            // Raise valid on a new result, drop it once the consumer takes
            // the transaction.
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_first_reg  <= s_data.first_sample;
                        cur_second_reg <= s_data.second_sample;
                        run_cnt_reg    <= '0;
                        state_reg      <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (run_go) begin
                        state_reg <= ST_CALC_A;
                    end else begin
                        // End of run: rebase the phase, or zero it if the cap
                        // cut the run short; the current frame becomes previous.
                        if (phase_reg >= {1'b0, new_frames_reg}) begin
                            phase_reg <= phase_reg - {1'b0, new_frames_reg};
                        end else begin
                            phase_reg <= '0;
                        end
                        prev_first_reg  <= cur_first_reg;
                        prev_second_reg <= cur_second_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_CALC_A: begin
                    if (rsp.done) begin
                        first_res_reg <= rsp.result;
                        state_reg     <= ST_CALC_B;
                    end
                end
                ST_CALC_B: begin
                    // Keep the result aside; the output register may still be held.
                    if (rsp.done) begin
                        second_res_reg <= rsp.result;
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // Hold until the output register is free, then advance.
                    if (emit_go) begin
                        m_data_reg.first_out  <= swap_bytes(first_res_reg);
                        m_data_reg.second_out <= swap_bytes(second_res_reg);
                        m_data_reg.run_end    <= run_last;
                        phase_reg             <= phase_sum;
                        run_cnt_reg           <= run_cnt_reg + 1'b1;
                        state_reg             <= ST_CHECK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    `SLR_ASSERT_NOW(a_run_cap, aclk, aresetn, 1'b1, run_cnt_reg <= RUN_CNT_W'(MAX_RUN), "run count past cap")
    `SLR_ASSERT_NOW(a_done_expected, aclk, aresetn, rsp.done, (state_reg == ST_CALC_A) || (state_reg == ST_CALC_B), "unexpected unit result")
    `SLR_ASSERT_NOW(a_div_nonzero, aclk, aresetn, req.start, new_frames_reg != '0, "launch with zero divisor")
    `SLR_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after accept")

endmodule

FILE: hdl/slr_lerp_unit.sv
// Shared multiply and restoring-divide unit: (a*(div-ph) + b*ph) / div.
`include "stereo_linear_resampler_core_macros.svh"

module slr_lerp_unit
    import slr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lerp_req_t req,
    output lerp_rsp_t rsp
);

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL_A,
        U_MUL_B,
        U_SUM,
        U_ABS,
        U_DIV,
        U_FIX
    } unit_state_t;

    unit_state_t state_reg;
    logic [STEP_W-1:0] step_reg;
    logic done_reg;

    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] b_reg;
    logic [FRAMES_W-1:0]        ph_reg;
    logic [FRAMES_W-1:0]        wt_reg;
    logic [FRAMES_W-1:0]        div_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [MAG_W-1:0]           rem_reg;
    logic [MAG_W-1:0]           dsh_reg;
    logic [QUOT_W-1:0]          q_reg;
    logic                       neg_reg;
    logic [SAMPLE_W-1:0]        result_reg;

    logic signed [SAMPLE_W-1:0] mul_x;
    logic signed [FRAMES_W:0]   mul_y;
    logic signed [PROD_W-1:0]   product;
    logic [ACC_W-1:0]           mag;
    logic                       ge;

    // One multiplier, shared between the two weighted terms.
    always_comb begin
        mul_x   = (state_reg == U_MUL_A) ? a_reg : b_reg;
        mul_y   = (state_reg == U_MUL_A) ? {1'b0, wt_reg} : {1'b0, ph_reg};
        product = mul_x * mul_y;
        mag     = acc_reg[ACC_W-1] ? (-acc_reg) : acc_reg;
        ge      = (rem_reg >= dsh_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE: begin
                    if (req.start) begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        ph_reg    <= req.ph;
                        wt_reg    <= req.div - req.ph;
                        div_reg   <= req.div;
                        state_reg <= U_MUL_A;
                    end
                end
                U_MUL_A: begin
                    prod_reg  <= product;
                    state_reg <= U_MUL_B;
                end
                U_MUL_B: begin
                    acc_reg   <= {prod_reg[PROD_W-1], prod_reg};
                    prod_reg  <= product;
                    state_reg <= U_SUM;
                end
                U_SUM: begin
                    acc_reg   <= acc_reg + {prod_reg[PROD_W-1], prod_reg};
                    state_reg <= U_ABS;
                end
                U_ABS: begin
                    // Divide magnitudes so the quotient truncates toward zero.
                    rem_reg   <= mag[MAG_W-1:0];
                    neg_reg   <= acc_reg[ACC_W-1];
                    dsh_reg   <= {div_reg, {(SAMPLE_W - 1){1'b0}}};
                    step_reg  <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV: begin
                    if (ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg    <= {q_reg[QUOT_W-2:0], ge};
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(QUOT_W - 1)) begin
                        state_reg <= U_FIX;
                    end
                end
                U_FIX: begin
                    result_reg <= neg_reg ? (-q_reg) : q_reg;
                    done_reg   <= 1'b1;
                    state_reg  <= U_IDLE;
                end
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

    `SLR_ASSERT_NOW(a_start_idle, aclk, aresetn, req.start, state_reg == U_IDLE, "start while busy")
    `SLR_ASSERT_NOW(a_div_nonzero, aclk, aresetn, state_reg == U_DIV, div_reg != '0, "zero divisor")
    `SLR_ASSERT_NOW(a_rem_bound, aclk, aresetn, state_reg == U_DIV, {1'b0, rem_reg} < {dsh_reg, 1'b0}, "remainder out of range")

endmodule
